>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the reply line parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rlp_pkg.sv
// Shared types and constants of the reply line parser.
// Used by the front parser, the command queue, the result expander and the checker.
`timescale 1ns / 1ps

package rlp_pkg;

  localparam int RLP_QDEPTH = 4;
  localparam int RLP_QPTR_W = $clog2(RLP_QDEPTH);

  // Telnet bytes.
  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_DONT = 8'd254;
  localparam logic [7:0] BYTE_DO   = 8'd253;
  localparam logic [7:0] BYTE_WONT = 8'd252;
  localparam logic [7:0] BYTE_WILL = 8'd251;

  // Line characters.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [9:0] CODE_CLOSED = 10'd221;
  localparam logic [9:0] CODE_LOST   = 10'd421;
  localparam logic [3:0] CLASS_LOST  = 4'(CODE_LOST / 100);

  typedef enum logic [1:0] {
    KIND_REFUSAL = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_STREAM  = 2'd2
  } rlp_kind_t;

  // One queued command: a refusal expands to three result items, others to one.
  typedef struct packed {
    rlp_kind_t  kind;
    logic       verb_wont;
    logic [7:0] opt_byte;
    logic [9:0] code;
    logic [3:0] cls;
    logic       lost;
  } rlp_cmd_t;

endpackage

>>> rtl/rlp_front.sv
// Front parser: accepts server bytes, strips telnet sequences and parses reply lines.
// Pushes one command per finished event into the command queue. Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output rlp_pkg::rlp_cmd_t q_cmd
);
  import rlp_pkg::*;

  typedef enum logic [2:0] {
    TN_IDLE = 3'b001,
    TN_CMD  = 3'b010,
    TN_OPT  = 3'b100
  } tn_state_t;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_SPACE = 2'd1;
  localparam logic [1:0] SEP_DASH  = 2'd2;
  localparam logic [1:0] SEP_OTHER = 2'd3;

  tn_state_t  tn_r, tn_nxt;
  logic       verb_r, verb_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [3:0] dig_r [3];
  logic [3:0] dig_nxt [3];
  logic       dv_r, dv_nxt;
  logic [1:0] sep_r, sep_nxt;
  logic [9:0] first_r, first_nxt;
  logic       cont_r, cont_nxt;

  logic       accept;
  logic [7:0] b;
  logic       eos;
  logic       eof_exp;
  logic       is_digit;
  logic [3:0] digit_val;
  logic [9:0] line_code;
  logic       code_ok;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign eos       = in_tuser[0];
  assign eof_exp   = in_tuser[1];
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit_val = is_digit ? b[3:0] : 4'd0;

  assign line_code = 10'(dig_r[0]) * 10'd100 + 10'(dig_r[1]) * 10'd10 + 10'(dig_r[2]);
  assign code_ok   = pos_r[2] && dv_r && (sep_r == SEP_SPACE || sep_r == SEP_DASH)
                     && (line_code != 10'd0);

  always_comb begin
    tn_nxt    = tn_r;
    verb_nxt  = verb_r;
    pos_nxt   = pos_r;
    dig_nxt   = dig_r;
    dv_nxt    = dv_r;
    sep_nxt   = sep_r;
    first_nxt = first_r;
    cont_nxt  = cont_r;
    q_push    = 1'b0;
    q_cmd     = '0;
    if (accept) begin
      if (eos) begin
        q_push   = 1'b1;
        q_cmd.kind = KIND_STREAM;
        if (eof_exp) begin
          q_cmd.code = CODE_CLOSED;
        end else begin
          q_cmd.code = CODE_LOST;
          q_cmd.cls  = CLASS_LOST;
          q_cmd.lost = 1'b1;
        end
        tn_nxt    = TN_IDLE;
        verb_nxt  = 1'b0;
        pos_nxt   = 3'd0;
        dig_nxt   = '{default: 4'd0};
        dv_nxt    = 1'b0;
        sep_nxt   = SEP_NONE;
        first_nxt = 10'd0;
        cont_nxt  = 1'b0;
      end else begin
        unique case (tn_r)
          TN_CMD: begin
            if (b == BYTE_WILL || b == BYTE_WONT) begin
              verb_nxt = 1'b0;
              tn_nxt   = TN_OPT;
            end else if (b == BYTE_DO || b == BYTE_DONT) begin
              verb_nxt = 1'b1;
              tn_nxt   = TN_OPT;
            end else begin
              tn_nxt = TN_IDLE;
            end
          end
          TN_OPT: begin
            tn_nxt          = TN_IDLE;
            q_push          = 1'b1;
            q_cmd.kind      = KIND_REFUSAL;
            q_cmd.verb_wont = verb_r;
            q_cmd.opt_byte  = b;
          end
          default: begin
            priority if (b == BYTE_IAC) begin
              tn_nxt = TN_CMD;
            end else if (b == CHAR_CR) begin
              tn_nxt = TN_IDLE;
            end else if (b != CHAR_LF) begin
              // Keep a character: the first three are digits, the fourth the separator.
              if (pos_r < 3'd3) begin
                dig_nxt[pos_r[1:0]] = digit_val;
                if (pos_r == 3'd0) begin
                  dv_nxt = is_digit;
                end else if (!is_digit) begin
                  dv_nxt = 1'b0;
                end
              end else if (pos_r == 3'd3) begin
                sep_nxt = (b == CHAR_SPACE) ? SEP_SPACE :
                          (b == CHAR_DASH)  ? SEP_DASH  : SEP_OTHER;
              end
              if (!pos_r[2]) begin
                pos_nxt = pos_r + 3'd1;
              end
            end else begin
              pos_nxt = 3'd0;
              dig_nxt = '{default: 4'd0};
              dv_nxt  = 1'b0;
              sep_nxt = SEP_NONE;
              if (code_ok) begin
                if (sep_r == SEP_DASH) begin
                  if (first_r == 10'd0) begin
                    first_nxt = line_code;
                  end
                  cont_nxt = 1'b1;
                end else if (!cont_r || line_code == first_r) begin
                  // A space line closes the reply unless a different multi-line reply is open.
                  q_push     = 1'b1;
                  q_cmd.kind = KIND_REPLY;
                  q_cmd.code = line_code;
                  q_cmd.cls  = dig_r[0];
                  q_cmd.lost = (line_code == CODE_LOST);
                  first_nxt  = 10'd0;
                  cont_nxt   = 1'b0;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tn_r    <= TN_IDLE;
      verb_r  <= 1'b0;
      pos_r   <= 3'd0;
      dig_r   <= '{default: 4'd0};
      dv_r    <= 1'b0;
      sep_r   <= SEP_NONE;
      first_r <= 10'd0;
      cont_r  <= 1'b0;
    end else begin
      tn_r    <= tn_nxt;
      verb_r  <= verb_nxt;
      pos_r   <= pos_nxt;
      dig_r   <= dig_nxt;
      dv_r    <= dv_nxt;
      sep_r   <= sep_nxt;
      first_r <= first_nxt;
      cont_r  <= cont_nxt;
    end
  end

endmodule

>>> rtl/rlp_fifo.sv
// Short command queue between the front parser and the result expander.
// Depth comes from rlp_pkg; the head entry is visible whenever the queue is not empty.
`timescale 1ns / 1ps

module rlp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rlp_pkg::rlp_cmd_t push_cmd,
  input  logic              pop,
  output rlp_pkg::rlp_cmd_t head,
  output logic              empty,
  output logic              full
);
  import rlp_pkg::*;

  rlp_cmd_t              mem_r [RLP_QDEPTH];
  logic [RLP_QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RLP_QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RLP_QPTR_W:0]   count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (RLP_QPTR_W + 1)'(RLP_QDEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/rlp_back.sv
// Result expander: turns queued commands into result items on the output register.
// A refusal becomes three items, a reply or stream end one. Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rlp_pkg::rlp_cmd_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import rlp_pkg::*;

  localparam logic [1:0] BEAT_IAC  = 2'd0;
  localparam logic [1:0] BEAT_VERB = 2'd1;
  localparam logic [1:0] BEAT_OPT  = 2'd2;

  logic [1:0]  beat_r, beat_nxt;
  logic        valid_r, valid_nxt;
  logic [23:0] data_r, data_nxt;
  logic [1:0]  user_r, user_nxt;
  logic        last_r, last_nxt;
  logic        load;

  assign load       = (!valid_r || out_tready) && !q_empty;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  always_comb begin
    beat_nxt  = beat_r;
    valid_nxt = valid_r && !out_tready;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      user_nxt  = head.kind;
      if (head.kind == KIND_REFUSAL) begin
        // tdata: send_byte, then zero code, class and lost flag.
        unique case (beat_r)
          BEAT_IAC: begin
            data_nxt = {16'd0, BYTE_IAC};
            last_nxt = 1'b0;
            beat_nxt = BEAT_VERB;
          end
          BEAT_VERB: begin
            data_nxt = {16'd0, (head.verb_wont ? BYTE_WONT : BYTE_DONT)};
            last_nxt = 1'b0;
            beat_nxt = BEAT_OPT;
          end
          default: begin
            data_nxt = {16'd0, head.opt_byte};
            last_nxt = 1'b1;
            beat_nxt = BEAT_IAC;
            q_pop    = 1'b1;
          end
        endcase
      end else begin
        data_nxt = {1'b0, head.lost, head.cls, head.code, 8'd0};
        last_nxt = 1'b1;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_IAC;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> rtl/reply_line_parser_with_telnet_refusal_top.sv
// Reply line parser with telnet refusal. Accepts one server byte per cycle while the
// four-entry command queue has room. A telnet refusal leaves the output register as
// three items, and the queue absorbs short bursts of refusals. A completed reply or
// a stream end is written into the command queue and then loaded into the output
// register, where it is offered as one item.
// Depends on rlp_pkg, rlp_front, rlp_fifo and rlp_back.
`timescale 1ns / 1ps

module reply_line_parser_with_telnet_refusal_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] end_of_stream, [1] eof_expected
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] send_byte, [17:8] reply_code,
                                  // [21:18] reply_class, [22] server_lost, [23] zero
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // last_of_run
);
  import rlp_pkg::*;

  rlp_cmd_t push_cmd;
  rlp_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  rlp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  rlp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rlp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/rlp_checker.sv
// Port-level checker of the reply line parser, bound to the top level.
// Depends on rlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import rlp_pkg::*;

  logic       out_fire;
  logic       is_stream;
  logic       stream_ok;

  assign out_fire  = out_tvalid && out_tready;
  assign is_stream = (out_tuser == KIND_STREAM);
  assign stream_ok = (out_tdata[17:8] == CODE_CLOSED && out_tdata[21:18] == 4'd0
                      && !out_tdata[22])
                  || (out_tdata[17:8] == CODE_LOST && out_tdata[21:18] == CLASS_LOST
                      && out_tdata[22]);

  // A stalled item holds its payload.
  `RLP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result item changed")

  // Replies and stream ends are always one-item runs.
  `RLP_ASSERT_IMPL(a_single_last, out_tvalid && out_tuser != KIND_REFUSAL, out_tlast, "single result item without tlast")

  // A stream end reports either a normal close or a lost server.
  `RLP_ASSERT_IMPL(a_stream_code, out_tvalid && is_stream, stream_ok, "bad stream end result")

  // The bytes of a refusal follow each other without a gap.
  `RLP_ASSERT_NEXT(a_refusal_run, out_fire && out_tuser == KIND_REFUSAL && !out_tlast, out_tvalid && out_tuser == KIND_REFUSAL, "refusal run broken")

  // Right after reset the block is empty: input open, no result item offered.
  `RLP_ASSERT_IMPL(a_clean_reset, $rose(rst_n), in_tready && !out_tvalid, "block not empty after reset")

endmodule

bind reply_line_parser_with_telnet_refusal_top rlp_checker u_rlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/sv/tb_reply_line_parser_with_telnet_refusal_top.sv
// Self-checking testbench for the reply line parser with telnet refusal.
// Streams server bytes with random gaps and stalls and checks every result item
// against its own parser model. Depends on rlp_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_reply_line_parser_with_telnet_refusal_top;
  import rlp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 30;

  typedef enum logic [1:0] {TN_IDLE, TN_CMD, TN_OPT} tn_phase_t;
  typedef enum logic [1:0] {SEP_NONE, SEP_SPACE, SEP_DASH, SEP_OTHER} sep_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       eof_ok;
  } server_byte_t;

  typedef struct {
    rlp_kind_t  kind;
    logic [7:0] send;
    logic [9:0] code;
    logic [3:0] cls;
    logic       lost;
    logic       last;
  } parser_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'b00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  server_byte_t   byte_queue[$];
  parser_result_t predicted_items[$];
  server_byte_t   in_flight;

  int  sent_count = 0;
  int  total_items = 0;
  int  directed_count = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  hold_done = 1'b0;
  wire calm_tail = (sent_count + CALM_ITEMS >= total_items);

  // Parser model state.
  tn_phase_t  tn_phase;
  logic       refuse_wont;
  logic [2:0] line_pos;
  logic [3:0] digits[3];
  logic       digits_ok;
  sep_kind_t  sep_kind;
  logic [9:0] open_code;
  logic       multi_open;

  reply_line_parser_with_telnet_refusal_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_line();
    line_pos = 3'd0;
    digits[0] = 4'd0;
    digits[1] = 4'd0;
    digits[2] = 4'd0;
    digits_ok = 1'b0;
    sep_kind = SEP_NONE;
  endfunction

  function automatic void reset_parser();
    tn_phase = TN_IDLE;
    refuse_wont = 1'b0;
    clear_line();
    open_code = 10'd0;
    multi_open = 1'b0;
  endfunction

  function automatic void push_result(rlp_kind_t k, logic [7:0] sb, logic [9:0] code,
                                      logic [3:0] cls, logic lost, logic last);
    parser_result_t r;
    r.kind = k;
    r.send = sb;
    r.code = code;
    r.cls = cls;
    r.lost = lost;
    r.last = last;
    predicted_items.push_back(r);
  endfunction

  // Advances the parser model by one accepted byte and queues the items it causes.
  function automatic void parse_byte(server_byte_t it);
    logic [7:0] b;
    logic       is_digit;
    int         code;
    logic       dash;
    b = it.data;
    if (it.eos) begin
      if (it.eof_ok)
        push_result(KIND_STREAM, 8'd0, CODE_CLOSED, 4'd0, 1'b0, 1'b1);
      else
        push_result(KIND_STREAM, 8'd0, CODE_LOST, CLASS_LOST, 1'b1, 1'b1);
      reset_parser();
      return;
    end
    case (tn_phase)
      TN_CMD: begin
        if (b == BYTE_WILL || b == BYTE_WONT) begin
          refuse_wont = 1'b0;
          tn_phase = TN_OPT;
        end else if (b == BYTE_DO || b == BYTE_DONT) begin
          refuse_wont = 1'b1;
          tn_phase = TN_OPT;
        end else begin
          tn_phase = TN_IDLE;
        end
      end
      TN_OPT: begin
        tn_phase = TN_IDLE;
        push_result(KIND_REFUSAL, BYTE_IAC, 10'd0, 4'd0, 1'b0, 1'b0);
        push_result(KIND_REFUSAL, refuse_wont ? BYTE_WONT : BYTE_DONT, 10'd0, 4'd0, 1'b0, 1'b0);
        push_result(KIND_REFUSAL, b, 10'd0, 4'd0, 1'b0, 1'b1);
      end
      default: begin
        if (b == BYTE_IAC) begin
          tn_phase = TN_CMD;
        end else if (b == CHAR_CR) begin
          // Carriage returns never reach the line.
        end else if (b != CHAR_LF) begin
          is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
          if (line_pos < 3) begin
            digits[line_pos] = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;
            if (line_pos == 0)
              digits_ok = is_digit;
            else if (!is_digit)
              digits_ok = 1'b0;
          end else if (line_pos == 3) begin
            if (b == CHAR_SPACE)
              sep_kind = SEP_SPACE;
            else if (b == CHAR_DASH)
              sep_kind = SEP_DASH;
            else
              sep_kind = SEP_OTHER;
          end
          if (line_pos < 4)
            line_pos++;
        end else begin
          code = 0;
          if (line_pos >= 4 && digits_ok && (sep_kind == SEP_SPACE || sep_kind == SEP_DASH))
            code = digits[0] * 100 + digits[1] * 10 + digits[2];
          dash = (sep_kind == SEP_DASH);
          clear_line();
          if (code != 0) begin
            if (dash) begin
              // Later dash lines keep the code of the first one.
              if (open_code == 10'd0)
                open_code = 10'(code);
              multi_open = 1'b1;
            end else begin
              if (10'(code) == open_code)
                multi_open = 1'b0;
              if (!multi_open) begin
                open_code = 10'd0;
                push_result(KIND_REPLY, 8'd0, 10'(code), 4'(code / 100),
                            code == CODE_LOST, 1'b1);
              end
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  function automatic int pick_code();
    case ($urandom_range(0, 5))
      0: return CODE_LOST;
      1: return CODE_CLOSED;
      2: return 0;
      3: return $urandom_range(0, 999);
      default: return $urandom_range(100, 999);
    endcase
  endfunction

  task automatic add_byte(logic [7:0] b);
    server_byte_t it;
    it.data = b;
    it.eos = 1'b0;
    it.eof_ok = 1'($urandom_range(0, 1));
    byte_queue.push_back(it);
  endtask

  task automatic add_end(logic eof_ok);
    server_byte_t it;
    it.data = 8'($urandom_range(0, 255));
    it.eos = 1'b1;
    it.eof_ok = eof_ok;
    byte_queue.push_back(it);
  endtask

  task automatic add_telnet(logic [7:0] cmd, logic [7:0] opt);
    add_byte(BYTE_IAC);
    add_byte(cmd);
    if (cmd >= BYTE_WILL && cmd <= BYTE_DONT)
      add_byte(opt);
  endtask

  task automatic add_random_telnet();
    logic [7:0] cmd;
    if ($urandom_range(0, 4) == 0)
      cmd = 8'($urandom_range(0, 255));
    else
      cmd = 8'($urandom_range(251, 255));
    add_telnet(cmd, 8'($urandom_range(0, 255)));
  endtask

  // A line with a three-digit code, a separator and a little text; telnet
  // commands may appear inside the text.
  task automatic add_line(int code, logic [7:0] sep);
    int n;
    add_byte(8'(CHAR_ZERO + code / 100));
    add_byte(8'(CHAR_ZERO + (code / 10) % 10));
    add_byte(8'(CHAR_ZERO + code % 10));
    add_byte(sep);
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        add_random_telnet();
      else
        add_byte(8'($urandom_range(32, 126)));
    end
    if ($urandom_range(0, 1))
      add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endtask

  task automatic add_junk_line();
    int n;
    n = $urandom_range(0, 5);
    repeat (n) add_byte(8'($urandom_range(32, 126)));
    add_byte(CHAR_LF);
  endtask

  initial begin : stimulus
    int kind;
    int code;
    int n;
    add_telnet(BYTE_WILL, 8'h00);
    add_telnet(BYTE_DO, 8'hFF);
    add_telnet(BYTE_WONT, CHAR_CR);
    add_telnet(BYTE_DONT, CHAR_LF);
    add_telnet(BYTE_IAC, 8'h00);
    add_telnet(8'h00, 8'h00);
    add_line(999, CHAR_SPACE);
    // Stream end inside a telnet sequence sends no refusal.
    add_byte(BYTE_IAC);
    add_end(1'b0);
    add_end(1'b1);
    directed_count = byte_queue.size();

    while (byte_queue.size() < directed_count + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind <= 6) begin
        add_line(pick_code(), CHAR_SPACE);
      end else if (kind <= 10) begin
        code = pick_code();
        add_line(code, CHAR_DASH);
        n = $urandom_range(0, 3);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: add_line(pick_code(), CHAR_DASH);
            1: add_line(pick_code(), CHAR_SPACE);
            default: add_junk_line();
          endcase
        end
        add_line(code, CHAR_SPACE);
      end else if (kind <= 13) begin
        add_random_telnet();
      end else if (kind == 14) begin
        add_junk_line();
      end else if (kind == 15) begin
        add_line(pick_code(), 8'($urandom_range(32, 126)));
      end else if (kind <= 17) begin
        n = $urandom_range(1, 4);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end else if (kind == 18) begin
        add_end(1'($urandom_range(0, 1)));
      end else begin
        add_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end
    end
    total_items = byte_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(byte_queue.size() == 0 && !in_tvalid && predicted_items.size() == 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Driver: offers queued bytes, with random idle bursts before new items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      reset_parser();
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_flight);
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 16) - 1;
          in_tvalid <= 1'b0;
        end else begin
          in_flight = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= in_flight.data;
          in_tuser <= {in_flight.eof_ok, in_flight.eos};
        end
      end
    end
  end

  // Monitor: checks accepted result items and applies back-pressure, once with
  // a long hold-off so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_items.size() == 0) begin
          $error("unexpected result item: kind %0d data %h last %b",
                 out_tuser, out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          parser_result_t r;
          r = predicted_items.pop_front();
          check_field("result_kind", r.kind, out_tuser);
          check_field("send_byte", r.send, out_tdata[7:0]);
          check_field("reply_code", r.code, out_tdata[17:8]);
          check_field("reply_class", r.cls, out_tdata[21:18]);
          check_field("server_lost", r.lost, out_tdata[22]);
          check_field("last_of_run", r.last, out_tlast);
        end
      end
      if (!hold_done && sent_count >= directed_count + 8) begin
        hold_done = 1'b1;
        out_stall = HOLD_CYCLES;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(1, 16) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rlp_pkg.sv
rtl/rlp_front.sv
rtl/rlp_fifo.sv
rtl/rlp_back.sv
rtl/reply_line_parser_with_telnet_refusal_top.sv
rtl/rlp_checker.sv
tb/sv/tb_reply_line_parser_with_telnet_refusal_top.sv
